[src/count_min_sketch_core_assert.svh]
// assertion macros for the sketch core
`ifndef COUNT_MIN_SKETCH_CORE_ASSERT_SVH
`define COUNT_MIN_SKETCH_CORE_ASSERT_SVH

`define CMS_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("cms check failed");

`define CMS_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("cms check failed");

`endif

[src/cms_pkg.sv]
package cms_pkg;
  localparam int ROWS = 4;
  localparam int MAX_COLUMNS = 4096;
  localparam int ROW_W = 2;
  localparam int COL_W = 12;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH = ROWS * MAX_COLUMNS;
  localparam logic [32:0] HASH_PRIME = 33'd4294967291;

  localparam logic [2:0] REG_SEED0 = 3'd0;
  localparam logic [2:0] REG_SEED3 = 3'd3;
  localparam logic [2:0] REG_COLS  = 3'd4;
  localparam logic [2:0] REG_ROWS  = 3'd5;

  localparam logic CMD_UPDATE   = 1'b0;
  localparam logic CMD_ESTIMATE = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] key;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [63:0] data;
  } cfg_word_t;
endpackage

[src/cms_if.sv]
interface cms_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/cms_ram.sv]
module cms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/count_min_sketch_core.sv]
// channel | dir | fields
// in_ch   | in  | command (1), key (32)
// out_ch  | out | estimate (32)
// cfg_ch  | in  | index (3), data (64)
// after reset a clearing pass zeroes all 16384 counters; in_ch is not ready then
// per active row: multiply, add, prime fold, bit-serial column remainder over the 32 hash bits, read, update
// in_ch takes no new item until the previous one has run through all its rows, and an estimate through the push
// state; an estimate waits while out_ch still holds an untaken word; cfg_ch is always ready
module count_min_sketch_core (
  input logic clk,
  input logic rst_n,
  cms_if.sink   in_ch,
  cms_if.source out_ch,
  cms_if.sink   cfg_ch
);
  import cms_pkg::*;
  `include "count_min_sketch_core_assert.svh"

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_MUL = 4'd2, S_ADD = 4'd3,
                         S_FOLD = 4'd4, S_DIV = 4'd5, S_RD = 4'd6, S_ACC = 4'd7,
                         S_PUSH = 4'd8;

  logic [3:0]  state_r, state_nxt;
  logic [63:0] seed_r [ROWS];
  logic [12:0] cols_r;
  logic [2:0]  rows_r;
  logic [ADDR_W-1:0] clr_r;
  logic        cmd_r;
  logic [31:0] key_r;
  logic [ROW_W-1:0] row_r;
  logic [2:0]  nrows_r;
  logic [12:0] ncols_r;
  logic [31:0] h_r;
  logic [COL_W-1:0] rem_r;
  logic [4:0]  bit_r;
  logic [31:0] least_r;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r;

  logic [31:0] prod;
  logic [32:0] folded;
  logic [COL_W:0] rem_sh;
  logic [COL_W+1:0] trial;
  logic        last_row;
  logic [31:0] row_min;
  logic        in_fire;
  logic        out_free;
  logic        mem_we;
  logic [ADDR_W-1:0] mem_addr, mem_waddr;
  logic [31:0] mem_wdata, mem_rdata;
  logic [2:0]  eff_rows;
  logic [12:0] eff_cols;
  in_word_t    in_w;
  cfg_word_t   cfg_w;

  assign in_w  = in_ch.data;
  assign cfg_w = cfg_ch.data;
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_data_r;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    eff_rows = rows_r;
    if (rows_r == 3'd0) eff_rows = 3'd1;
    if (rows_r > 3'(ROWS)) eff_rows = 3'(ROWS);
    eff_cols = cols_r;
    if (cols_r == 13'd0) eff_cols = 13'd1;
    if (cols_r > 13'(MAX_COLUMNS)) eff_cols = 13'(MAX_COLUMNS);
  end

  assign prod = seed_r[row_r][63:32] * key_r;
  assign folded = ({1'b0, h_r} >= HASH_PRIME) ? ({1'b0, h_r} - HASH_PRIME) : {1'b0, h_r};
  // restoring remainder, one hash bit per cycle
  assign rem_sh = {rem_r, h_r[31]};
  assign trial = {1'b0, rem_sh} - {1'b0, ncols_r};
  assign last_row = (3'(row_r) + 3'd1) == nrows_r;
  assign row_min = (mem_rdata < least_r) ? mem_rdata : least_r;

  assign mem_addr = {row_r, rem_r};
  assign mem_we = (state_r == S_CLEAR) || (state_r == S_ACC && cmd_r == CMD_UPDATE);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_r : mem_addr;
  assign mem_wdata = (state_r == S_CLEAR) ? 32'd0 : mem_rdata + 32'd1;

  cms_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_addr), .rdata(mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == ADDR_W'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_fire) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_FOLD;
      S_FOLD:  state_nxt = S_DIV;
      S_DIV:   if (bit_r == 5'd0) state_nxt = S_RD;
      S_RD:    state_nxt = S_ACC;
      S_ACC: begin
        if (!last_row) state_nxt = S_MUL;
        else if (cmd_r == CMD_ESTIMATE) state_nxt = S_PUSH;
        else state_nxt = S_IDLE;
      end
      S_PUSH:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (state_r == S_PUSH && out_free) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ROWS; i++) seed_r[i] <= '0;
      cols_r <= 13'd4096;
      rows_r <= 3'd4;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_w.index <= REG_SEED3) seed_r[cfg_w.index[ROW_W-1:0]] <= cfg_w.data;
        else if (cfg_w.index == REG_COLS) cols_r <= cfg_w.data[12:0];
        else if (cfg_w.index == REG_ROWS) rows_r <= cfg_w.data[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_r <= in_w.command;
          key_r <= in_w.key;
          row_r <= '0;
          nrows_r <= eff_rows;
          ncols_r <= eff_cols;
          least_r <= 32'hFFFF_FFFF;
        end
      end
      S_MUL: h_r <= prod;
      S_ADD: h_r <= h_r + seed_r[row_r][31:0];
      S_FOLD: begin
        h_r <= folded[31:0];
        rem_r <= '0;
        bit_r <= 5'd31;
      end
      S_DIV: begin
        if (trial[COL_W+1]) rem_r <= rem_sh[COL_W-1:0];
        else rem_r <= trial[COL_W-1:0];
        h_r <= {h_r[30:0], 1'b0};
        bit_r <= bit_r - 5'd1;
      end
      S_ACC: begin
        least_r <= row_min;
        if (!last_row) row_r <= row_r + 1'b1;
      end
      S_PUSH: if (out_free) out_data_r <= least_r;
      default: ;
    endcase
  end

  `CMS_ASSERT_IMPL(a_ready_idle, in_ch.ready, state_r == S_IDLE)
  `CMS_ASSERT_IMPL(a_no_write_est, state_r == S_ACC && cmd_r == CMD_ESTIMATE, !mem_we)
  `CMS_ASSERT_IMPL(a_row_range, state_r != S_CLEAR && state_r != S_IDLE, 3'(row_r) < nrows_r)
  `CMS_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data))
endmodule
